>>> src/sbsm_pkg.sv
// Shared types and constants of the serial bank switch mapper.
package sbsm_pkg;

  // Bus command codes
  localparam logic [1:0] CMD_CPU_RD = 2'd0;
  localparam logic [1:0] CMD_CPU_WR = 2'd1;
  localparam logic [1:0] CMD_PPU_RD = 2'd2;
  localparam logic [1:0] CMD_PPU_WR = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_MAPPED   = 2'd1;
  localparam logic [1:0] ST_RAM      = 2'd2;
  localparam logic [1:0] ST_ABSORBED = 2'd3;

  // Serial commit targets, address bits 14:13
  localparam logic [1:0] TGT_CONTROL = 2'd0;
  localparam logic [1:0] TGT_CHR_LO  = 2'd1;
  localparam logic [1:0] TGT_CHR_HI  = 2'd2;
  localparam logic [1:0] TGT_PRG     = 2'd3;

  // Program modes, control bits 3:2
  localparam logic [1:0] PRG_MODE_FIX_LO = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HI = 2'd3;

  // Configuration register indexes
  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  localparam logic [4:0] CTRL_RST       = 5'h1c;
  localparam logic [4:0] CTRL_FORCE16K  = 5'h0c;
  localparam logic [4:0] PRG_COUNT_RST  = 5'd16;
  localparam logic [3:0] PRG_HIGH_RST   = 4'd15;
  localparam logic [2:0] SHIFT_LEN      = 3'd5;

  localparam int RAM_BYTES_DEF = 8192;
  localparam int RAM_WINDOW    = 8192;
  localparam int OUTQ_DEPTH    = 3;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] mapped_address;
    logic [1:0]  mirror_mode;
  } map_res_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [12:0] offset;
    logic [7:0]  data;
  } ram_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] mapped_address;
    logic [7:0]  read_data;
    logic [1:0]  mirror_mode;
  } out_item_t;

endpackage

>>> src/serial_bank_switch_mapper_unit.sv
// Top level of the serial bank switch mapper.
// A result is registered in stage 1 (decode + RAM read), then in the result queue, before it is offered.
// Throughput: one access per cycle while in_stall is low; the single-port cart RAM sees at most one per item.
// A three-entry result queue lets input keep flowing while results wait.
// Reset (rst, synchronous): registers take their power-up values, then the
// cart RAM is swept to zero, all min(RAM_BYTES, 8192) entries, with in_stall high.
module serial_bank_switch_mapper_unit import sbsm_pkg::*; #(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [17:0] mapped_address,
  output logic [7:0]  read_data,
  output logic [1:0]  mirror_mode,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  logic       in_accept;
  logic       ram_busy;
  logic [7:0] ram_q;
  map_res_t   dec_res;
  ram_req_t   ram_req;

  // stage 1: decoded result waiting for the RAM read data
  logic       s1_valid;
  map_res_t   s1_res;
  logic       s1_rd;

  out_item_t  push_item;
  out_item_t  head;
  logic [1:0] q_count;
  logic [2:0] occupancy;

  // registers are plain flops; writes are always taken
  assign cfg_ready = 1'b1;

  // room for the queued results plus the one in flight
  assign occupancy = {1'b0, q_count} + {2'b00, s1_valid};
  assign in_stall  = ram_busy || (occupancy >= 3'(OUTQ_DEPTH));
  assign in_accept = in_valid && !in_stall;

  sbsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (in_accept),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .res        (dec_res),
    .ram_req    (ram_req)
  );

  sbsm_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .rst  (rst),
    .req  (ram_req),
    .busy (ram_busy),
    .q    (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res <= dec_res;
      s1_rd  <= ram_req.rd;
    end
  end

  // read data is only reported for a CPU read of the RAM window
  always_comb begin
    push_item.status         = s1_res.status;
    push_item.mapped_address = s1_res.mapped_address;
    push_item.read_data      = s1_rd ? ram_q : 8'd0;
    push_item.mirror_mode    = s1_res.mirror_mode;
  end

  sbsm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_item (push_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign status         = head.status;
  assign mapped_address = head.mapped_address;
  assign read_data      = head.read_data;
  assign mirror_mode    = head.mirror_mode;

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count < 2'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    ram_busy |-> !s1_valid && !out_valid)
    else $error("item in flight during RAM clearing sweep");

  a_read_data_only_ram: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_data != 8'd0) |-> (status == ST_RAM))
    else $error("read data on a non-RAM result");

  a_mapped_only_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_MAPPED) |-> (mapped_address == 18'd0))
    else $error("mapped address on an unmapped result");

endmodule

>>> src/sbsm_ctrl.sv
// Bank registers, serial load register and address translation.
module sbsm_ctrl import sbsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [15:0] address,
  input  logic [7:0] write_data,
  output map_res_t   res,
  output ram_req_t   ram_req
);

  logic [4:0] prg_count;
  logic [5:0] chr_count;
  logic [4:0] shift_bits, shift_bits_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_bits, control_bits_next;
  logic [4:0] chr_lo_4k, chr_lo_4k_next;
  logic [4:0] chr_hi_4k, chr_hi_4k_next;
  logic [4:0] chr_8k, chr_8k_next;
  logic [2:0] prg_32k, prg_32k_next;
  logic [3:0] prg_lo_16k, prg_lo_16k_next;
  logic [3:0] prg_hi_16k, prg_hi_16k_next;

  always_comb begin
    logic       ram_win;
    logic       ppu_low;
    logic [4:0] shift_new;
    logic [2:0] cnt_inc;
    logic [4:0] count_m1;
    ram_win  = (address[15:13] == 3'b011);
    ppu_low  = (address[15:13] == 3'b000);
    shift_new = {write_data[0], shift_bits[4:1]};
    cnt_inc  = shift_count + 3'd1;
    count_m1 = prg_count - 5'd1;

    shift_bits_next   = shift_bits;
    shift_count_next  = shift_count;
    control_bits_next = control_bits;
    chr_lo_4k_next    = chr_lo_4k;
    chr_hi_4k_next    = chr_hi_4k;
    chr_8k_next       = chr_8k;
    prg_32k_next      = prg_32k;
    prg_lo_16k_next   = prg_lo_16k;
    prg_hi_16k_next   = prg_hi_16k;

    res.status         = ST_NONE;
    res.mapped_address = '0;
    ram_req.rd     = 1'b0;
    ram_req.wr     = 1'b0;
    ram_req.offset = address[12:0];
    ram_req.data   = write_data;

    unique case (command)
      CMD_CPU_RD: begin
        if (ram_win) begin
          res.status = ST_RAM;
          ram_req.rd = accept;
        end else if (address[15]) begin
          res.status = ST_MAPPED;
          if (control_bits[3]) begin
            res.mapped_address = {(address[14] ? prg_hi_16k : prg_lo_16k), address[13:0]};
          end else begin
            res.mapped_address = {prg_32k, address[14:0]};
          end
        end
      end
      CMD_CPU_WR: begin
        if (ram_win) begin
          res.status = ST_RAM;
          ram_req.wr = accept;
        end else if (address[15]) begin
          res.status = ST_ABSORBED;
          if (write_data[7]) begin
            shift_bits_next   = '0;
            shift_count_next  = '0;
            control_bits_next = control_bits | CTRL_FORCE16K;
          end else if (cnt_inc >= SHIFT_LEN) begin
            shift_bits_next  = '0;
            shift_count_next = '0;
            unique case (address[14:13])
              TGT_CONTROL: control_bits_next = shift_new;
              TGT_CHR_LO: begin
                if (control_bits[4]) begin
                  chr_lo_4k_next = shift_new;
                end else begin
                  chr_8k_next = shift_new;
                end
              end
              TGT_CHR_HI: begin
                if (control_bits[4]) begin
                  chr_hi_4k_next = shift_new;
                end
              end
              TGT_PRG: begin
                priority if (control_bits[3:2] == PRG_MODE_FIX_LO) begin
                  prg_lo_16k_next = '0;
                  prg_hi_16k_next = shift_new[3:0];
                end else if (control_bits[3:2] == PRG_MODE_FIX_HI) begin
                  prg_lo_16k_next = shift_new[3:0];
                  prg_hi_16k_next = count_m1[3:0];
                end else begin
                  prg_32k_next = shift_new[3:1];
                end
              end
              default: ;
            endcase
          end else begin
            shift_bits_next  = shift_new;
            shift_count_next = cnt_inc;
          end
        end
      end
      CMD_PPU_RD: begin
        if (ppu_low) begin
          res.status = ST_MAPPED;
          if (chr_count == '0) begin
            res.mapped_address = {5'd0, address[12:0]};
          end else if (control_bits[4]) begin
            res.mapped_address = {1'b0, (address[12] ? chr_hi_4k : chr_lo_4k), address[11:0]};
          end else begin
            res.mapped_address = {chr_8k, address[12:0]};
          end
        end
      end
      CMD_PPU_WR: begin
        if (ppu_low) begin
          if (chr_count == '0) begin
            res.status         = ST_MAPPED;
            res.mapped_address = {5'd0, address[12:0]};
          end else begin
            res.status = ST_ABSORBED;
          end
        end
      end
      default: ;
    endcase

    // mirroring reflects control after this access
    res.mirror_mode = control_bits_next[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count    <= PRG_COUNT_RST;
      chr_count    <= '0;
      shift_bits   <= '0;
      shift_count  <= '0;
      control_bits <= CTRL_RST;
      chr_lo_4k    <= '0;
      chr_hi_4k    <= '0;
      chr_8k       <= '0;
      prg_32k      <= '0;
      prg_lo_16k   <= '0;
      prg_hi_16k   <= PRG_HIGH_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRG_COUNT: prg_count <= cfg_data[4:0];
          CFG_CHR_COUNT: chr_count <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        shift_bits   <= shift_bits_next;
        shift_count  <= shift_count_next;
        control_bits <= control_bits_next;
        chr_lo_4k    <= chr_lo_4k_next;
        chr_hi_4k    <= chr_hi_4k_next;
        chr_8k       <= chr_8k_next;
        prg_32k      <= prg_32k_next;
        prg_lo_16k   <= prg_lo_16k_next;
        prg_hi_16k   <= prg_hi_16k_next;
      end
    end
  end

  a_shift_count_bound: assert property (@(posedge clk) disable iff (rst)
    shift_count < SHIFT_LEN)
    else $error("serial load count passed its length");

  a_no_access_without_accept: assert property (@(posedge clk) disable iff (rst)
    (ram_req.rd || ram_req.wr) |-> accept)
    else $error("cart RAM access without a transfer");

endmodule

>>> src/sbsm_ram.sv
// On-cart RAM with a registered read port and a clearing sweep after reset.
module sbsm_ram import sbsm_pkg::*; #(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  ram_req_t req,
  output logic     busy,
  output logic [7:0] q
);

  localparam int DEPTH = (RAM_BYTES < RAM_WINDOW) ? RAM_BYTES : RAM_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [14:0] D1 = 15'(DEPTH);
  localparam logic [14:0] D2 = 15'(2 * DEPTH);
  localparam logic [14:0] D3 = 15'(3 * DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] idx;

  // window offset modulo depth; exact while offset < 4 * DEPTH, which holds for DEPTH >= 2048
  always_comb begin
    logic [14:0] off;
    logic [14:0] red;
    off = {2'b00, req.offset};
    priority if (off >= D3) begin
      red = off - D3;
    end else if (off >= D2) begin
      red = off - D2;
    end else if (off >= D1) begin
      red = off - D1;
    end else begin
      red = off;
    end
    idx = red[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (req.wr) begin
      mem[idx] <= req.data;
    end
    if (req.rd) begin
      q <= mem[idx];
    end
  end

endmodule

>>> src/sbsm_outq.sv
// Three-entry result queue in front of the output channel.
module sbsm_outq import sbsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t head,
  output logic [1:0] count
);

  out_item_t  entries [OUTQ_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
